### rtl/core/baro_sensor_compensation_core_defines.svh
// assertion macros for the barometric compensation core
`ifndef BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`ifndef SYNTH
`define BSC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define BSC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define BSC_ASSERT(lbl, prop)
`define BSC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### rtl/core/bsc_pkg.sv
// shared types, constants and helpers for the barometric compensation core
package bsc_pkg;
   localparam int DataWidth = 32;
   localparam int CountWidth = $clog2(DataWidth);

   localparam logic [2:0] CSR_AC_SIGNED   = 3'd0;
   localparam logic [2:0] CSR_AC_UNSIGNED = 3'd1;
   localparam logic [2:0] CSR_B_PACK      = 3'd2;
   localparam logic [2:0] CSR_M_PACK      = 3'd3;
   localparam logic [2:0] CSR_OSS         = 3'd4;

   localparam logic MODE_TEMP  = 1'b0;
   localparam logic MODE_PRESS = 1'b1;

   typedef struct packed {
      logic                 done;
      logic [DataWidth-1:0] result;
   } unit_rsp_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] neg_if(input logic [31:0] v, input logic n);
      return n ? (32'd0 - v) : v;
   endfunction
endpackage

### rtl/core/bsc_mul.sv
// bit-serial shift-add multiplier, low 32 bits of the product
module bsc_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bsc_pkg::DataWidth-1:0] op_a,
   input  logic [bsc_pkg::DataWidth-1:0] op_b,
   output logic                         busy,
   output bsc_pkg::unit_rsp_type        rsp
);
   import bsc_pkg::*;

   logic [DataWidth-1:0]  a_ff, b_ff, acc_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic                  busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CountWidth'(DataWidth - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= {a_ff[DataWidth-2:0], 1'b0};
         b_ff <= {1'b0, b_ff[DataWidth-1:1]};
      end
   end

   assign busy       = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;
endmodule

### rtl/core/bsc_div.sv
// bit-serial restoring unsigned divider, one quotient bit per cycle
module bsc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bsc_pkg::DataWidth-1:0] dividend,
   input  logic [bsc_pkg::DataWidth-1:0] divisor,
   output logic                         busy,
   output bsc_pkg::unit_rsp_type        rsp
);
   import bsc_pkg::*;

   logic [DataWidth-1:0]  q_ff, d_ff, rem_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic                  busy_ff, done_ff;
   logic [DataWidth:0]    shifted, trial;

   assign shifted = {rem_ff, q_ff[DataWidth-1]};
   assign trial   = shifted - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CountWidth'(DataWidth - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (!trial[DataWidth]) begin
            rem_ff <= trial[DataWidth-1:0];
            q_ff   <= {q_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DataWidth-1:0];
            q_ff   <= {q_ff[DataWidth-2:0], 1'b0};
         end
      end
   end

   assign busy       = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = q_ff;
endmodule

### rtl/core/baro_sensor_compensation_core.sv
// barometric sensor compensation core: sequencer, calibration registers, result register
// each multiply or divide pass runs through its own bit-serial unit, a multiplier or a divider
// temperature transaction: one multiply and two divides
// pressure transaction: ten multiplies and one divide
// one transaction at a time; the next is taken once the result is registered
// synchronous active-high reset clears calibration registers, stored B5 and control state
`include "baro_sensor_compensation_core_defines.svh"
module baro_sensor_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [18:0] req_raw_reading,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic        rsp_div_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);
   import bsc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_T_MUL, ST_T_DEN, ST_T_DIV1, ST_T_DIV2,
      ST_P_SQ, ST_P_X1, ST_P_X2, ST_P_B3, ST_P_X1B, ST_P_X2B, ST_P_B4, ST_P_B7,
      ST_P_CHK, ST_P_DIV, ST_P_SQP, ST_P_M3038, ST_P_M7357, ST_P_FIN, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [47:0] ac_s_ff, ac_u_ff;
   logic [31:0] b_ff, m_ff;
   logic [1:0]  oss_ff;
   logic [31:0] b5_ff, x1_ff, x2_ff, sq_ff, b3_ff, b4_ff, b7_ff, p_ff, res_ff;
   logic        mode_ff, err_ff, pend_ff;
   logic [18:0] raw_ff;
   logic        rsp_valid_ff, rsp_kind_ff, rsp_err_ff;
   logic [31:0] rsp_value_ff;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, b6, den, mcs, tq, b3_sum;
   logic        is_mul, is_div, mul_start, div_start, mul_busy, div_busy;
   logic [31:0] mul_a, mul_b, div_n, div_d;
   unit_rsp_type mul_rsp, div_rsp;

   assign ac1 = sx16(ac_s_ff[47:32]);
   assign ac2 = sx16(ac_s_ff[31:16]);
   assign ac3 = sx16(ac_s_ff[15:0]);
   assign ac4 = {16'd0, ac_u_ff[47:32]};
   assign ac5 = {16'd0, ac_u_ff[31:16]};
   assign ac6 = {16'd0, ac_u_ff[15:0]};
   assign b1  = sx16(b_ff[31:16]);
   assign b2  = sx16(b_ff[15:0]);
   assign mc  = sx16(m_ff[31:16]);
   assign md  = sx16(m_ff[15:0]);
   assign b6  = b5_ff - 32'd4000;
   assign den = x1_ff + md;
   assign mcs = {mc[20:0], 11'd0};
   assign tq  = 32'($signed(b5_ff + 32'd8) >>> 4);
   assign b3_sum = ({ac1[29:0], 2'b00} + x1_ff + x2_ff) << oss_ff;

   always_comb begin
      is_mul = 1'b0;
      is_div = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      div_n  = '0;
      div_d  = '0;
      unique case (state_ff)
         ST_T_MUL: begin
            is_mul = 1'b1;
            mul_a  = {16'd0, raw_ff[15:0]} - ac6;
            mul_b  = ac5;
         end
         ST_T_DIV1: begin
            is_div = 1'b1;
            div_n  = neg_if(mcs, mcs[31]);
            div_d  = neg_if(den, den[31]);
         end
         ST_T_DIV2: begin
            is_div = 1'b1;
            div_n  = neg_if(tq, tq[31]);
            div_d  = 32'd10;
         end
         ST_P_SQ: begin
            is_mul = 1'b1;
            mul_a  = b6;
            mul_b  = b6;
         end
         ST_P_X1: begin
            is_mul = 1'b1;
            mul_a  = b2;
            mul_b  = sq_ff;
         end
         ST_P_X2: begin
            is_mul = 1'b1;
            mul_a  = ac2;
            mul_b  = b6;
         end
         ST_P_X1B: begin
            is_mul = 1'b1;
            mul_a  = ac3;
            mul_b  = b6;
         end
         ST_P_X2B: begin
            is_mul = 1'b1;
            mul_a  = b1;
            mul_b  = sq_ff;
         end
         ST_P_B4: begin
            is_mul = 1'b1;
            mul_a  = ac4;
            mul_b  = 32'($signed(x1_ff + x2_ff + 32'd2) >>> 2) + 32'd32768;
         end
         ST_P_B7: begin
            is_mul = 1'b1;
            mul_a  = {13'd0, raw_ff} - b3_ff;
            mul_b  = 32'd50000 >> oss_ff;
         end
         ST_P_DIV: begin
            is_div = 1'b1;
            div_n  = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
            div_d  = b4_ff;
         end
         ST_P_SQP: begin
            is_mul = 1'b1;
            mul_a  = 32'($signed(p_ff) >>> 8);
            mul_b  = 32'($signed(p_ff) >>> 8);
         end
         ST_P_M3038: begin
            is_mul = 1'b1;
            mul_a  = x1_ff;
            mul_b  = 32'd3038;
         end
         ST_P_M7357: begin
            is_mul = 1'b1;
            mul_a  = 32'd0 - 32'd7357;
            mul_b  = p_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_start = is_mul && !pend_ff;
   assign div_start = is_div && !pend_ff;

   bsc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .busy(mul_busy), .rsp(mul_rsp)
   );

   bsc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n), .divisor(div_d),
      .busy(div_busy), .rsp(div_rsp)
   );

   logic [31:0] mp, dq;
   assign mp = mul_rsp.result;
   assign dq = div_rsp.result;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ac_s_ff <= '0;
         ac_u_ff <= '0;
         b_ff    <= '0;
         m_ff    <= '0;
         oss_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AC_SIGNED:   ac_s_ff <= csr_data;
            CSR_AC_UNSIGNED: ac_u_ff <= csr_data;
            CSR_B_PACK:      b_ff    <= csr_data[31:0];
            CSR_M_PACK:      m_ff    <= csr_data[31:0];
            CSR_OSS:         oss_ff  <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         b5_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((is_mul || is_div) && !pend_ff) begin
            pend_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_mode;
                  raw_ff   <= req_raw_reading;
                  err_ff   <= 1'b0;
                  res_ff   <= '0;
                  state_ff <= (req_mode == MODE_TEMP) ? ST_T_MUL : ST_P_SQ;
               end
            end
            ST_T_MUL: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x1_ff    <= 32'($signed(mp) >>> 15);
                  state_ff <= ST_T_DEN;
               end
            end
            ST_T_DEN: begin
               if (den == 32'd0) begin
                  err_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_T_DIV1;
               end
            end
            ST_T_DIV1: begin
               if (pend_ff && div_rsp.done) begin
                  pend_ff  <= 1'b0;
                  b5_ff    <= x1_ff + neg_if(dq, mcs[31] ^ den[31]);
                  state_ff <= ST_T_DIV2;
               end
            end
            ST_T_DIV2: begin
               if (pend_ff && div_rsp.done) begin
                  pend_ff  <= 1'b0;
                  res_ff   <= neg_if(dq, tq[31]);
                  state_ff <= ST_DONE;
               end
            end
            ST_P_SQ: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  sq_ff    <= 32'($signed(mp) >>> 12);
                  state_ff <= ST_P_X1;
               end
            end
            ST_P_X1: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x1_ff    <= 32'($signed(mp) >>> 11);
                  state_ff <= ST_P_X2;
               end
            end
            ST_P_X2: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x2_ff    <= 32'($signed(mp) >>> 11);
                  state_ff <= ST_P_B3;
               end
            end
            ST_P_B3: begin
               b3_ff    <= 32'($signed(b3_sum + 32'd2) >>> 2);
               state_ff <= ST_P_X1B;
            end
            ST_P_X1B: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x1_ff    <= 32'($signed(mp) >>> 13);
                  state_ff <= ST_P_X2B;
               end
            end
            ST_P_X2B: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x2_ff    <= 32'($signed(mp) >>> 16);
                  state_ff <= ST_P_B4;
               end
            end
            ST_P_B4: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  b4_ff    <= mp >> 15;
                  state_ff <= ST_P_B7;
               end
            end
            ST_P_B7: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  b7_ff    <= mp;
                  state_ff <= ST_P_CHK;
               end
            end
            ST_P_CHK: begin
               if (b4_ff == 32'd0) begin
                  err_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_P_DIV;
               end
            end
            ST_P_DIV: begin
               if (pend_ff && div_rsp.done) begin
                  pend_ff  <= 1'b0;
                  p_ff     <= b7_ff[31] ? {dq[30:0], 1'b0} : dq;
                  state_ff <= ST_P_SQP;
               end
            end
            ST_P_SQP: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x1_ff    <= mp;
                  state_ff <= ST_P_M3038;
               end
            end
            ST_P_M3038: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x1_ff    <= 32'($signed(mp) >>> 16);
                  state_ff <= ST_P_M7357;
               end
            end
            ST_P_M7357: begin
               if (pend_ff && mul_rsp.done) begin
                  pend_ff  <= 1'b0;
                  x2_ff    <= 32'($signed(mp) >>> 16);
                  state_ff <= ST_P_FIN;
               end
            end
            ST_P_FIN: begin
               res_ff   <= p_ff + 32'($signed(x1_ff + x2_ff + 32'd3791) >>> 4);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= mode_ff;
                  rsp_err_ff   <= err_ff;
                  rsp_value_ff <= err_ff ? 32'd0 : res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_value     = $signed(rsp_value_ff);
   assign rsp_div_error = rsp_err_ff;

   `BSC_ASSERT(a_units_exclusive, !(mul_busy && div_busy))
   `BSC_ASSERT_IMP(a_err_zero, rsp_valid && rsp_div_error, rsp_value == 32'sd0)
   `BSC_ASSERT_IMP(a_accept_leaves_idle, req_valid && !req_stall, ##1 state_ff != ST_IDLE)
endmodule
